// File: rtl/spfs_pkg.sv
`default_nettype none

package spfs_pkg;

    // fixed payload widths of the channels
    localparam int CMD_W       = 2;
    localparam int SLOT_W      = 10;
    localparam int ELEM_W      = 32;
    localparam int NEXT_W      = 11;
    localparam int STATUS_W    = 2;
    // common width for range compares between counters and slot indices
    localparam int CMP_W       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POOL_FULL  = 2'd1,
        ST_RANGE      = 2'd2,
        ST_STACK_FULL = 2'd3
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // input transaction taken, latch it and issue reads
        logic commit;  // update state and load the result register
    } t_ctrl;

endpackage

`default_nettype wire

// File: rtl/spfs_if.sv
`default_nettype none

interface spfs_in_if;
    logic                             valid;
    logic                             ready;
    logic [spfs_pkg::CMD_W-1:0]       cmd;
    logic [spfs_pkg::SLOT_W-1:0]      slot_index;
    logic [spfs_pkg::ELEM_W-1:0]      element_data;

    modport source (output valid, cmd, slot_index, element_data, input ready);
    modport sink   (input valid, cmd, slot_index, element_data, output ready);
endinterface

interface spfs_out_if;
    logic                             valid;
    logic                             ready;
    logic [spfs_pkg::SLOT_W-1:0]      used_slot;
    logic [spfs_pkg::ELEM_W-1:0]      read_value;
    logic [spfs_pkg::NEXT_W-1:0]      next_slot;
    logic [spfs_pkg::STATUS_W-1:0]    status;

    modport source (output valid, used_slot, read_value, next_slot, status, input ready);
    modport sink   (input valid, used_slot, read_value, next_slot, status, output ready);
endinterface

`default_nettype wire

// File: rtl/spfs_ram.sv
`default_nettype none

module spfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/spfs_ctrl.sv
`default_nettype none

module spfs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output spfs_pkg::t_ctrl     o_ctrl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   load;
    logic   commit;

    assign o_in_ready = (r_state == S_IDLE);
    assign load       = i_in_valid && (r_state == S_IDLE);
    // result register frees up in the same cycle it is taken
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (load) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ctrl.load   = load;
    assign o_ctrl.commit = commit;

    a_commit_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == S_IDLE) && r_out_valid)
        else $error("commit did not return to idle with a result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && (r_state == S_EXEC) |-> !commit)
        else $error("result overwritten while still waiting");

endmodule

`default_nettype wire

// File: rtl/spfs_dp.sv
`default_nettype none

module spfs_dp #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spfs_pkg::t_ctrl                   i_ctrl,
    input  wire logic [spfs_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [spfs_pkg::SLOT_W-1:0]       i_slot_index,
    input  wire logic [spfs_pkg::ELEM_W-1:0]       i_element_data,
    output logic      [spfs_pkg::SLOT_W-1:0]       o_used_slot,
    output logic      [spfs_pkg::ELEM_W-1:0]       o_read_value,
    output logic      [spfs_pkg::NEXT_W-1:0]       o_next_slot,
    output logic      [spfs_pkg::STATUS_W-1:0]     o_status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // latched transaction
    spfs_pkg::t_cmd           r_cmd;
    logic [spfs_pkg::SLOT_W-1:0] r_idx;
    logic [DATA_WIDTH-1:0]    r_data;

    // pool state
    logic [CNT_W-1:0]         r_high_water, n_high_water;
    logic [CNT_W-1:0]         r_free_count, n_free_count;
    logic [IDX_W-1:0]         r_top, n_top;

    // result register
    logic [spfs_pkg::SLOT_W-1:0]   r_used_slot, n_used_slot;
    logic [spfs_pkg::ELEM_W-1:0]   r_read_value, n_read_value;
    logic [spfs_pkg::NEXT_W-1:0]   r_next_slot, n_next_slot;
    spfs_pkg::t_status             r_status, n_status;

    // memory ports
    logic                     elem_wr_en;
    logic [IDX_W-1:0]         elem_wr_addr;
    logic                     elem_rd_en;
    logic [DATA_WIDTH-1:0]    elem_rd_data;
    logic                     stack_wr_en;
    logic                     stack_rd_en;
    logic [IDX_W-1:0]         stack_rd_data;
    logic [IDX_W-1:0]         slot;
    logic                     idx_out_of_range;

    // reads are issued with the incoming transaction, data is ready in the exec cycle
    assign elem_rd_en  = i_ctrl.load && (spfs_pkg::t_cmd'(i_cmd) == spfs_pkg::CMD_GET);
    // entry below the top, becomes the new top after a pop
    assign stack_rd_en = i_ctrl.load && (spfs_pkg::t_cmd'(i_cmd) == spfs_pkg::CMD_ADD);

    spfs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (elem_wr_en),
        .i_wr_addr (elem_wr_addr),
        .i_wr_data (r_data),
        .i_rd_en   (elem_rd_en),
        .i_rd_addr (IDX_W'(i_slot_index)),
        .o_rd_data (elem_rd_data)
    );

    spfs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stack_wr_en),
        .i_wr_addr (r_free_count[IDX_W-1:0]),
        .i_wr_data (IDX_W'(r_idx)),
        .i_rd_en   (stack_rd_en),
        .i_rd_addr (IDX_W'(r_free_count - CNT_W'(2))),
        .o_rd_data (stack_rd_data)
    );

    assign idx_out_of_range =
        (spfs_pkg::CMP_W'(r_idx) >= spfs_pkg::CMP_W'(r_high_water));

    always_comb begin
        n_high_water = r_high_water;
        n_free_count = r_free_count;
        n_top        = r_top;
        n_used_slot  = '0;
        n_read_value = '0;
        n_status     = spfs_pkg::ST_OK;
        elem_wr_en   = 1'b0;
        stack_wr_en  = 1'b0;
        slot         = r_top;

        unique case (r_cmd)
            spfs_pkg::CMD_ADD: begin
                if (r_free_count != '0) begin
                    slot         = r_top;
                    n_free_count = r_free_count - CNT_W'(1);
                    n_top        = stack_rd_data;
                    elem_wr_en   = i_ctrl.commit;
                    n_used_slot  = spfs_pkg::SLOT_W'(r_top);
                end else if (r_high_water < CAP_CNT) begin
                    slot         = IDX_W'(r_high_water);
                    n_high_water = r_high_water + CNT_W'(1);
                    elem_wr_en   = i_ctrl.commit;
                    n_used_slot  = spfs_pkg::SLOT_W'(r_high_water);
                end else begin
                    n_status = spfs_pkg::ST_POOL_FULL;
                end
            end
            spfs_pkg::CMD_REMOVE: begin
                if (idx_out_of_range) begin
                    n_status = spfs_pkg::ST_RANGE;
                end else if (r_free_count == CAP_CNT) begin
                    n_status = spfs_pkg::ST_STACK_FULL;
                end else begin
                    stack_wr_en  = i_ctrl.commit;
                    n_free_count = r_free_count + CNT_W'(1);
                    n_top        = IDX_W'(r_idx);
                end
            end
            spfs_pkg::CMD_GET: begin
                if (idx_out_of_range) begin
                    n_status = spfs_pkg::ST_RANGE;
                end else begin
                    n_read_value = spfs_pkg::ELEM_W'(elem_rd_data);
                end
            end
            spfs_pkg::CMD_CLEAR: begin
                n_high_water = '0;
                n_free_count = '0;
            end
        endcase

        if (n_free_count != '0) begin
            n_next_slot = spfs_pkg::NEXT_W'(n_top);
        end else begin
            n_next_slot = spfs_pkg::NEXT_W'(n_high_water);
        end
    end

    assign elem_wr_addr = slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water <= '0;
            r_free_count <= '0;
        end else if (i_ctrl.commit) begin
            r_high_water <= n_high_water;
            r_free_count <= n_free_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= spfs_pkg::t_cmd'(i_cmd);
            r_idx  <= i_slot_index;
            r_data <= DATA_WIDTH'(i_element_data);
        end
        if (i_ctrl.commit) begin
            r_top        <= n_top;
            r_used_slot  <= n_used_slot;
            r_read_value <= n_read_value;
            r_next_slot  <= n_next_slot;
            r_status     <= n_status;
        end
    end

    assign o_used_slot  = r_used_slot;
    assign o_read_value = r_read_value;
    assign o_next_slot  = r_next_slot;
    assign o_status     = r_status;

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CAP_CNT)
        else $error("free count beyond capacity");

    a_high_water_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= CAP_CNT)
        else $error("high-water count beyond capacity");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.commit && (r_cmd == spfs_pkg::CMD_ADD) && (r_free_count != '0)
        |=> (r_free_count == $past(r_free_count) - CNT_W'(1))
            && (r_high_water == $past(r_high_water)))
        else $error("add from free stack did not pop exactly one entry");

    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.commit) && (r_status == spfs_pkg::ST_POOL_FULL)
        |-> (r_high_water == CAP_CNT) && (r_free_count == '0))
        else $error("pool full reported with room left");

endmodule

`default_nettype wire

// File: rtl/slot_pool_with_free_stack_unit.sv
`default_nettype none
// exec commits a command into the result register once that register is free
// a new command is taken only in idle, so not before the last one is committed; the
//   slot store and free stack are read in the cycle a command is taken
// a waiting result does not stop the next command being taken, only its commit waits
// reset clears the high-water count and the free count; slot store and free
//   stack contents stay undefined, no clearing pass is run

module slot_pool_with_free_stack_unit #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spfs_in_if.sink     i_in,
    spfs_out_if.source  o_out
);

    // command bundle from the controller to the datapath
    spfs_pkg::t_ctrl ctrl;

    // two-state sequencer: idle takes a command transaction, exec commits it
    // into the pool state and the result register once that register is free
    spfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (ctrl)
    );

    // datapath: slot store and free stack memories, the two counters, a cached
    // copy of the stack top so an add never waits on the stack read, and the
    // result register
    spfs_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cmd          (i_in.cmd),
        .i_slot_index   (i_in.slot_index),
        .i_element_data (i_in.element_data),
        .o_used_slot    (o_out.used_slot),
        .o_read_value   (o_out.read_value),
        .o_next_slot    (o_out.next_slot),
        .o_status       (o_out.status)
    );

endmodule

`default_nettype wire
